>>> rtl/crrts_pkg.sv
`default_nettype none
package crrts_pkg;

	localparam int NUM_TASKS = 8;
	localparam int TASK_W    = 3;
	localparam int SP_W      = 32;
	localparam int REQ_W     = 3;

	localparam logic [REQ_W-1:0] REQ_INIT     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SET_SIZE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_YIELD    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_RETURNED = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SUSPEND  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_RESUME   = 3'd5;
	localparam logic [REQ_W-1:0] REQ_RESTART  = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RESET    = 3'd7;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic apply;
		logic init_rd;
		logic init_add;
		logic scan_step;
		logic fetch;
	} crrts_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             init_last;
		logic             found;
		logic             scan_last;
	} crrts_sts_t;

endpackage
`default_nettype wire

>>> rtl/crrts_ctrl.sv
`default_nettype none
module crrts_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire crrts_pkg::crrts_sts_t sts,
	output crrts_pkg::crrts_cmd_t    cmd,
	output logic                     busy,
	output logic                     done
);
	import crrts_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DECODE   = 3'd1;
	localparam logic [2:0] S_INIT_RD  = 3'd2;
	localparam logic [2:0] S_INIT_ADD = 3'd3;
	localparam logic [2:0] S_SCAN     = 3'd4;
	localparam logic [2:0] S_FETCH    = 3'd5;
	localparam logic [2:0] S_RESP     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.apply = 1'b1;
				if (sts.req == REQ_INIT)
					state_d = S_INIT_RD;
				else if (sts.req == REQ_YIELD || sts.req == REQ_RETURNED)
					state_d = S_SCAN;
				else
					state_d = S_RESP;
			end
			S_INIT_RD: begin
				cmd.init_rd = 1'b1;
				state_d     = S_INIT_ADD;
			end
			S_INIT_ADD: begin
				cmd.init_add = 1'b1;
				state_d      = sts.init_last ? S_RESP : S_INIT_RD;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.found)
					state_d = S_FETCH;
				else if (sts.scan_last)
					state_d = S_RESP;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule
`default_nettype wire

>>> rtl/crrts_dp.sv
`default_nettype none
module crrts_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire crrts_pkg::crrts_cmd_t       cmd,
	output crrts_pkg::crrts_sts_t            sts,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_data,
	input  wire logic [crrts_pkg::REQ_W-1:0] req_type,
	input  wire logic [crrts_pkg::TASK_W-1:0] task_number,
	input  wire logic [crrts_pkg::SP_W-1:0]  sp_value,
	output logic                             dispatched,
	output logic [crrts_pkg::TASK_W-1:0]     next_task,
	output logic                             start_fresh,
	output logic [crrts_pkg::SP_W-1:0]       load_sp,
	output logic                             none_ready
);
	import crrts_pkg::*;

	localparam logic [TASK_W-1:0] LAST_TASK = TASK_W'(NUM_TASKS - 1);

	// per-task stores, no reset
	logic [SP_W-1:0] saved_sp_mem   [NUM_TASKS];
	logic [SP_W-1:0] start_sp_mem   [NUM_TASKS];
	logic [SP_W-1:0] stack_size_mem [NUM_TASKS];

	logic [REQ_W-1:0]     req_q;
	logic [TASK_W-1:0]    tn_q;
	logic [SP_W-1:0]      spv_q;
	logic                 grows_up_q;
	logic [TASK_W-1:0]    cur_q;
	logic [NUM_TASKS-1:0] fresh_q;
	logic [NUM_TASKS-1:0] susp_q;
	logic [TASK_W-1:0]    cnt_q;
	logic [SP_W-1:0]      run_q;
	logic [SP_W-1:0]      size_rd_q;
	logic [TASK_W-1:0]    t_q;
	logic                 res_disp_q;
	logic [TASK_W-1:0]    res_task_q;
	logic                 res_fresh_q;
	logic [SP_W-1:0]      load_sp_q;
	logic                 res_none_q;

	logic                 tn_ok;
	logic [TASK_W-1:0]    t_next;
	logic                 found;

	assign tn_ok  = {1'b0, tn_q} < (TASK_W+1)'(NUM_TASKS);
	assign t_next = (t_q == LAST_TASK) ? '0 : t_q + 1'b1;
	assign found  = !susp_q[t_next];

	assign sts.req       = req_q;
	assign sts.init_last = (cnt_q == LAST_TASK);
	assign sts.found     = found;
	assign sts.scan_last = (cnt_q == LAST_TASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			grows_up_q <= 1'b0;
		else if (cfg_we)
			grows_up_q <= cfg_data;
	end

	// request beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			tn_q  <= task_number;
			spv_q <= sp_value;
		end
	end

	// task flags and current task
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			fresh_q <= '1;
			susp_q  <= '0;
		end else if (cmd.apply) begin
			case (req_q)
				REQ_INIT: begin
					// task 0 is dispatched right away, so only it is not fresh
					fresh_q <= {{(NUM_TASKS-1){1'b1}}, 1'b0};
					susp_q  <= '0;
					cur_q   <= '0;
				end
				REQ_RETURNED: begin
					susp_q[cur_q]  <= 1'b1;
					fresh_q[cur_q] <= 1'b1;
				end
				REQ_SUSPEND: begin
					susp_q[cur_q] <= 1'b1;
				end
				REQ_RESUME: begin
					if (tn_ok)
						susp_q[tn_q] <= 1'b0;
				end
				REQ_RESTART: begin
					if (tn_ok) begin
						fresh_q[tn_q] <= 1'b1;
						susp_q[tn_q]  <= 1'b0;
					end
				end
				REQ_RESET: begin
					if (tn_ok) begin
						fresh_q[tn_q] <= 1'b1;
						susp_q[tn_q]  <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.scan_step && found) begin
			cur_q           <= t_next;
			fresh_q[t_next] <= 1'b0;
		end
	end

	// sequencing: init walk counter, running pointer, scan position
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			cnt_q <= '0;
			run_q <= spv_q;
			t_q   <= cur_q;
		end else if (cmd.init_add) begin
			cnt_q <= cnt_q + 1'b1;
			run_q <= grows_up_q ? run_q + size_rd_q : run_q - size_rd_q;
		end else if (cmd.scan_step) begin
			cnt_q <= cnt_q + 1'b1;
			t_q   <= t_next;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			res_disp_q  <= (req_q == REQ_INIT);
			res_task_q  <= '0;
			res_fresh_q <= (req_q == REQ_INIT);
			load_sp_q   <= (req_q == REQ_INIT) ? spv_q : '0;
			res_none_q  <= 1'b0;
		end else if (cmd.scan_step) begin
			if (found) begin
				res_disp_q  <= 1'b1;
				res_task_q  <= t_next;
				res_fresh_q <= fresh_q[t_next];
			end else if (sts.scan_last) begin
				res_none_q <= 1'b1;
			end
		end else if (cmd.fetch) begin
			load_sp_q <= res_fresh_q ? start_sp_mem[t_q] : saved_sp_mem[t_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && req_q == REQ_YIELD)
			saved_sp_mem[cur_q] <= spv_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && req_q == REQ_SET_SIZE && tn_ok)
			stack_size_mem[tn_q] <= spv_q;
		if (cmd.init_rd)
			size_rd_q <= stack_size_mem[cnt_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.init_rd)
			start_sp_mem[cnt_q] <= run_q;
	end

	assign dispatched  = res_disp_q;
	assign next_task   = res_task_q;
	assign start_fresh = res_fresh_q;
	assign load_sp     = load_sp_q;
	assign none_ready  = res_none_q;

endmodule
`default_nettype wire

>>> rtl/cooperative_round_robin_task_scheduler_core.sv
`default_nettype none
// Round-robin scheduler for a cooperative task kernel. Pulse start with a request while
// busy is low; busy stays high until the result beat, which is shown for exactly one
// cycle with done high and must be taken then, since the block cannot be held off.
// Every request gives one result. Set size, suspend, resume, restart and reset go from
// accept through a decode step straight to done. Yield and task-returned walk the task
// flags one entry per cycle (up to 8 steps) and, if a ready task is found, then read
// its stack pointer from its store. Init walks the 8 stack sizes through a single
// adder, with a read and an add step per task. The next request can be taken the cycle
// after done. stack_grows_up is written through the cfg port, which is always ready;
// write it only while the block is idle.
module cooperative_round_robin_task_scheduler_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [crrts_pkg::REQ_W-1:0]  req_type,
	input  wire logic [crrts_pkg::TASK_W-1:0] task_number,
	input  wire logic [crrts_pkg::SP_W-1:0]   sp_value,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic                         cfg_data,
	output logic                              done,
	output logic                              dispatched,
	output logic [crrts_pkg::TASK_W-1:0]      next_task,
	output logic                              start_fresh,
	output logic [crrts_pkg::SP_W-1:0]        load_sp,
	output logic                              none_ready
);
	import crrts_pkg::*;

	crrts_cmd_t cmd;
	crrts_sts_t sts;
	logic       ctrl_start;

	assign cfg_ready  = 1'b1;
	assign ctrl_start = start && !busy;

	crrts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl_start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	crrts_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.req_type    (req_type),
		.task_number (task_number),
		.sp_value    (sp_value),
		.dispatched  (dispatched),
		.next_task   (next_task),
		.start_fresh (start_fresh),
		.load_sp     (load_sp),
		.none_ready  (none_ready)
	);

endmodule
`default_nettype wire
